>>> src/multi_button_press_classifier_macros.svh
// assertion macros for the multi button press classifier
// expects aclk and aresetn in the scope where a macro is used
`ifndef MULTI_BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define MULTI_BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MBPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mbpc_pkg.sv
// shared types, codes and decode function for the button press classifier
// no dependencies
`default_nettype none

package mbpc_pkg;

    localparam int MAX_BUTTONS   = 4;
    localparam int TICK_W        = 8;
    localparam int PERIOD_W      = 12;
    localparam int TIME_W        = 13;
    localparam int COUNT_W       = 8;
    localparam int NIBBLE_W      = 4;
    localparam int WORD_W        = 16;
    localparam int MSG_W         = 4;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 12;

    localparam logic [COUNT_W-1:0] LONG_COUNT_MAX = 8'd250;

    // per-button event codes
    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_CLICK        = 3'd1,
        EV_LONG         = 3'd2,
        EV_LONG_RELEASE = 3'd5,
        EV_TWICE_LONG   = 3'd6
    } mbpc_event_t;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_BUTTON_ENABLE     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_ENABLE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PERIOD_MS    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_MIN_MS      = 8'd3;

    // message codes
    localparam logic [MSG_W-1:0] MSG_NONE          = 4'd0;
    localparam logic [MSG_W-1:0] MSG_RUN_CLICK     = 4'd1;
    localparam logic [MSG_W-1:0] MSG_RUN_LONG_REL  = 4'd2;
    localparam logic [MSG_W-1:0] MSG_RUN_TWICE     = 4'd3;
    localparam logic [MSG_W-1:0] MSG_ADD_CLICK     = 4'd4;
    localparam logic [MSG_W-1:0] MSG_ADD_LONG      = 4'd5;
    localparam logic [MSG_W-1:0] MSG_SUB_CLICK     = 4'd6;
    localparam logic [MSG_W-1:0] MSG_SUB_LONG      = 4'd7;
    localparam logic [MSG_W-1:0] MSG_S_CLICK       = 4'd8;
    localparam logic [MSG_W-1:0] MSG_S_LONG        = 4'd9;

    typedef struct packed {
        logic [MAX_BUTTONS-1:0] button_enable;
        logic [MAX_BUTTONS-1:0] long_press_enable;
        logic [PERIOD_W-1:0]    long_period_ms;
        logic [PERIOD_W-1:0]    click_min_ms;
    } mbpc_cfg_t;

    // listed single-button events map to a message, anything else to none
    function automatic logic [MSG_W-1:0] decode_word(input logic [WORD_W-1:0] w);
        logic [MSG_W-1:0] m;
        unique case (w)
            16'h0001: m = MSG_RUN_CLICK;
            16'h0005: m = MSG_RUN_LONG_REL;
            16'h0006: m = MSG_RUN_TWICE;
            16'h0010: m = MSG_ADD_CLICK;
            16'h0020: m = MSG_ADD_LONG;
            16'h0100: m = MSG_SUB_CLICK;
            16'h0200: m = MSG_SUB_LONG;
            16'h1000: m = MSG_S_CLICK;
            16'h2000: m = MSG_S_LONG;
            default:  m = MSG_NONE;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> src/mbpc_cfg.sv
// configuration register file of the button press classifier
// depends on mbpc_pkg
`default_nettype none

module mbpc_cfg
    import mbpc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output mbpc_cfg_t                   cfg
);

    mbpc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.button_enable     <= 4'hF;
            cfg_reg.long_press_enable <= 4'hF;
            cfg_reg.long_period_ms    <= 12'd1000;
            cfg_reg.click_min_ms      <= 12'd100;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BUTTON_ENABLE:     cfg_reg.button_enable     <= cfg_data[MAX_BUTTONS-1:0];
                CFG_LONG_PRESS_ENABLE: cfg_reg.long_press_enable <= cfg_data[MAX_BUTTONS-1:0];
                CFG_LONG_PERIOD_MS:    cfg_reg.long_period_ms    <= cfg_data;
                CFG_CLICK_MIN_MS:      cfg_reg.click_min_ms      <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/mbpc_button.sv
// press timer, long press counter and event state of one button
// depends on mbpc_pkg
`default_nettype none

module mbpc_button
    import mbpc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic                 enable,
    input  wire logic                 lp_en,
    input  wire logic                 level,
    input  wire logic [TICK_W-1:0]    tick_ms,
    input  wire mbpc_cfg_t            cfg,
    output logic [NIBBLE_W-1:0]       nibble
);

    logic [TIME_W-1:0]  time_reg, time_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    mbpc_event_t        ev_reg, ev_next;
    logic [TIME_W-1:0]  held_sum;
    logic [COUNT_W-1:0] count_inc;

    always_comb begin
        held_sum   = time_reg + {{(TIME_W-TICK_W){1'b0}}, tick_ms};
        count_inc  = (count_reg < LONG_COUNT_MAX) ? count_reg + 8'd1 : count_reg;
        time_next  = time_reg;
        count_next = count_reg;
        ev_next    = ev_reg;
        if (enable) begin
            if (!level) begin
                // held
                if (held_sum > {1'b0, cfg.long_period_ms}) begin
                    time_next = '0;
                    if (lp_en) begin
                        count_next = count_inc;
                        ev_next    = (count_inc > 8'd1) ? EV_TWICE_LONG : EV_LONG;
                    end
                end else begin
                    time_next = held_sum;
                end
            end else begin
                // released
                if (count_reg != '0) begin
                    if (lp_en) begin
                        ev_next = EV_LONG_RELEASE;
                    end
                end else if (time_reg > {1'b0, cfg.click_min_ms}) begin
                    ev_next = EV_CLICK;
                end else begin
                    ev_next = EV_NONE;
                end
                time_next  = '0;
                count_next = '0;
            end
        end
    end

    assign nibble = enable ? {1'b0, ev_next} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg  <= '0;
            count_reg <= '0;
            ev_reg    <= EV_NONE;
        end else if (step) begin
            time_reg  <= time_next;
            count_reg <= count_next;
            ev_reg    <= ev_next;
        end
    end

endmodule

`default_nettype wire

>>> src/multi_button_press_classifier.sv
// top level of the multi button press classifier: input register, per-button
// logic, word compare and message decode, result register
// depends on mbpc_pkg, mbpc_cfg, mbpc_button and the assertion macro header
//
// usage:
// - input stream: one request per scan tick, tick_ms and the four active-low
//   button levels; each request yields exactly one result request
// - result stream: message code, packed event word and a changed flag
// - config channel: cfg_valid/cfg_index/cfg_data, always ready; write only
//   while the block is idle
// - path: the accepting edge fills the input register, the tick moves on into
//   the result register once the result slot is free; throughput one tick per
//   cycle while m_tready holds, set by the single combinational per-button update
// - receiver stall: the result register holds, an empty input register still
//   takes one request, then s_tready drops until the result is taken
// - reset (aresetn low, synchronous): timers, counts, events and the last
//   word clear, registers return to their defaults, both streams go empty
`default_nettype none

`include "multi_button_press_classifier_macros.svh"

module multi_button_press_classifier
    import mbpc_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [15:0]            s_tdata,   // tick_ms[7:0], levels[11:8], zero pad
    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata,   // message[3:0], event_word[19:4], zero pad
    output logic [0:0]                  m_tuser,   // changed[0]
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    mbpc_cfg_t cfg;

    // input register
    logic                   in_valid_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [MAX_BUTTONS-1:0] levels_reg;

    // result register
    logic                   out_valid_reg;
    logic [MSG_W-1:0]       message_reg;
    logic [WORD_W-1:0]      word_reg;
    logic                   changed_reg;

    logic [WORD_W-1:0]      last_word_reg;
    logic [WORD_W-1:0]      word_next;
    logic                   changed_next;
    logic [MSG_W-1:0]       message_next;
    logic                   advance;

    // the tick in the input register moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mbpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // one lane per existing button, absent buttons give zero nibbles
    for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_btn
        if (i < NUM_BUTTONS) begin : g_on
            mbpc_button u_button (
                .aclk    (aclk),
                .aresetn (aresetn),
                .step    (advance),
                .enable  (cfg.button_enable[i]),
                .lp_en   (cfg.long_press_enable[i]),
                .level   (levels_reg[i]),
                .tick_ms (tick_reg),
                .cfg     (cfg),
                .nibble  (word_next[NIBBLE_W*i +: NIBBLE_W])
            );
        end else begin : g_off
            assign word_next[NIBBLE_W*i +: NIBBLE_W] = '0;
        end
    end

    // message only when the packed word moves
    assign changed_next = (word_next != last_word_reg);
    assign message_next = changed_next ? decode_word(word_next) : MSG_NONE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            tick_reg   <= s_tdata[7:0];
            levels_reg <= s_tdata[11:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_word_reg <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                last_word_reg <= word_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            message_reg <= message_next;
            word_reg    <= word_next;
            changed_reg <= changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, word_reg, message_reg};
    assign m_tuser  = changed_reg;

    // an unchanged word never carries a message
    `MBPC_ASSERT_SAME(a_msg_needs_change, m_tvalid && !m_tuser[0], m_tdata[3:0] == MSG_NONE, "message without change")
    // a tick that moves on always lands in the result register
    `MBPC_ASSERT_NEXT(a_advance_fills_out, advance, m_tvalid, "result lost after advance")
    // a held tick is not dropped while the result side stalls
    `MBPC_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg && m_tvalid, "held tick dropped")

endmodule

`default_nettype wire
